[design/fixed_buffer_bump_allocator_core_macros.svh]
// Assertion helpers used by the checker file.
`ifndef FIXED_BUFFER_BUMP_ALLOCATOR_CORE_MACROS_SVH
`define FIXED_BUFFER_BUMP_ALLOCATOR_CORE_MACROS_SVH

// Property that must hold at every clock edge outside reset.
`define FBBA_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("fbba assertion failed");

// Implication checked in the same cycle.
`define FBBA_ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("fbba implication failed");

// Implication checked in the next cycle.
`define FBBA_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("fbba next-cycle implication failed");

`endif

[design/fbba_pkg.sv]
`timescale 1ns / 1ps

package fbba_pkg;

    // Address and length widths the allocator is built for.
    localparam int ADDR_BITS = 32;
    localparam int LEN_BITS  = 24;

    // Operation codes.
    localparam logic [1:0] OP_ALLOC  = 2'd0;
    localparam logic [1:0] OP_RESIZE = 2'd1;
    localparam logic [1:0] OP_FREE   = 2'd2;
    localparam logic [1:0] OP_RESET  = 2'd3;

    // Status codes.
    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_NOSPACE  = 2'd1;
    localparam logic [1:0] ST_NOTOWNED = 2'd2;
    localparam logic [1:0] ST_NOTLAST  = 2'd3;

    // One request beat.
    typedef struct packed {
        logic [1:0]  operation;
        logic [24:0] request_len;
        logic [3:0]  align_log2;
        logic [31:0] block_addr;
        logic [24:0] block_len;
    } t_in_beat;

    // One result beat.
    typedef struct packed {
        logic        granted;
        logic [31:0] result_addr;
        logic [1:0]  status;
        logic        was_last;
        logic [24:0] used_bytes;
    } t_out_beat;

    // Region settings seen by the request logic.
    typedef struct packed {
        logic [31:0] region_base;
        logic [24:0] region_len;
    } t_region;

endpackage

[design/fbba_calc.sv]
`timescale 1ns / 1ps

module fbba_calc (
    input  fbba_pkg::t_in_beat  i_req,
    input  fbba_pkg::t_region   i_region,
    input  logic [24:0]         i_end_offset,
    output fbba_pkg::t_out_beat o_res
);
    import fbba_pkg::*;

    // Mask that wraps allocated addresses to the address space.
    localparam logic [32:0] AddrMask = (ADDR_BITS >= 33) ? {33{1'b1}} :
        33'(({64'd0, 1'b1} << ADDR_BITS) - 65'd1);

    logic [32:0] here;
    logic [15:0] amask;
    logic [15:0] pad;
    logic [26:0] alloc_end;
    logic [32:0] alloc_addr;
    logic        addr_ge;
    logic [31:0] off;
    logic [32:0] blk_end;
    logic        owned;
    logic        last;
    logic [26:0] grow_end;
    logic [24:0] n_end;

    always_comb begin
        // Allocate: round the current end address up and add the length.
        here       = {1'b0, i_region.region_base} + {8'd0, i_end_offset};
        amask      = (16'd1 << i_req.align_log2) - 16'd1;
        pad        = (16'd0 - here[15:0]) & amask;
        alloc_end  = {2'd0, i_end_offset} + {11'd0, pad} + {2'd0, i_req.request_len};
        alloc_addr = (here + {17'd0, pad}) & AddrMask;

        // Ownership and position of an existing block.
        addr_ge = i_req.block_addr >= i_region.region_base;
        off     = i_req.block_addr - i_region.region_base;
        blk_end = {1'b0, off} + {8'd0, i_req.block_len};
        owned   = addr_ge && (blk_end <= {8'd0, i_region.region_len});
        last    = blk_end == {8'd0, i_end_offset};

        grow_end = {2'd0, i_end_offset} + {2'd0, i_req.request_len}
                   - {2'd0, i_req.block_len};

        o_res.granted     = 1'b0;
        o_res.result_addr = 32'd0;
        o_res.status      = ST_OK;
        o_res.was_last    = 1'b0;
        n_end             = i_end_offset;

        unique case (i_req.operation)
            OP_ALLOC: begin
                if (alloc_end > {2'd0, i_region.region_len}) begin
                    o_res.status = ST_NOSPACE;
                end else begin
                    n_end             = alloc_end[24:0];
                    o_res.result_addr = alloc_addr[31:0];
                    o_res.granted     = 1'b1;
                end
            end
            OP_RESET: begin
                n_end         = 25'd0;
                o_res.granted = 1'b1;
            end
            OP_FREE: begin
                o_res.result_addr = i_req.block_addr;
                if (!owned) begin
                    o_res.status = ST_NOTOWNED;
                end else begin
                    o_res.was_last = last;
                    o_res.granted  = 1'b1;
                    if (last) begin
                        n_end = i_end_offset - i_req.block_len;
                    end
                end
            end
            OP_RESIZE: begin
                o_res.result_addr = i_req.block_addr;
                if (!owned) begin
                    o_res.status = ST_NOTOWNED;
                end else begin
                    o_res.was_last = last;
                    if (i_req.request_len <= i_req.block_len) begin
                        // A shrink always succeeds; only the last block gives space back.
                        o_res.granted = 1'b1;
                        if (last) begin
                            n_end = i_end_offset - i_req.block_len + i_req.request_len;
                        end
                    end else if (!last) begin
                        o_res.status = ST_NOTLAST;
                    end else if (grow_end > {2'd0, i_region.region_len}) begin
                        o_res.status = ST_NOSPACE;
                    end else begin
                        n_end         = grow_end[24:0];
                        o_res.granted = 1'b1;
                    end
                end
            end
            default: begin
                o_res.status = ST_OK;
            end
        endcase

        o_res.used_bytes = n_end;
    end

endmodule

[design/fixed_buffer_bump_allocator_core.sv]
`timescale 1ns / 1ps
// A request beat is held in the input register; the result register loads from it
// once it is empty or its result is taken, and the end offset is updated then too.
// Throughput: one request per cycle unless the output stalls; the end offset
// update is one add and compare path between the input and result registers.
// Reset (synchronous, active low) clears the end offset, both region registers
// and the valid flags of the input and result registers.

module fixed_buffer_bump_allocator_core (
    input  logic                i_clk,
    input  logic                i_rst_n,

    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  fbba_pkg::t_in_beat  i_in_data,

    output logic                o_out_valid,
    input  logic                i_out_stall,
    output fbba_pkg::t_out_beat o_out_data,

    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [2:0]          paddr,
    input  logic [31:0]         pwdata,
    output logic [31:0]         prdata,
    output logic                pready
);
    import fbba_pkg::*;

    // Register index is address bit 2.
    localparam logic REG_REGION_BASE = 1'b0;
    localparam logic REG_REGION_LEN  = 1'b1;

    // Largest region length the allocator accepts.
    localparam logic [63:0] LenLimit = 64'd1 << LEN_BITS;

    logic        r_in_valid;
    t_in_beat    r_in;
    logic        r_out_valid;
    t_out_beat   r_out;
    logic [24:0] r_end_offset;
    t_region     r_region;

    logic        out_free;
    logic        advance;
    logic        in_take;
    logic        cfg_write;
    logic [24:0] wr_len;
    t_out_beat   calc_res;

    assign out_free  = !r_out_valid || !i_out_stall;
    assign advance   = r_in_valid && out_free;
    assign in_take   = i_in_valid && !o_in_stall;
    assign o_in_stall = r_in_valid && !out_free;

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    // Configuration port.
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite;
    assign wr_len    = ({39'd0, pwdata[24:0]} > LenLimit) ? LenLimit[24:0] : pwdata[24:0];

    always_comb begin
        unique case (paddr[2])
            REG_REGION_BASE: prdata = r_region.region_base;
            REG_REGION_LEN:  prdata = {7'd0, r_region.region_len};
            default:         prdata = 32'd0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_region <= '0;
        end else if (cfg_write) begin
            if (paddr[2] == REG_REGION_LEN) begin
                r_region.region_len <= wr_len;
            end else begin
                r_region.region_base <= pwdata;
            end
        end
    end

    // Request logic between the input and result registers.
    fbba_calc u_calc (
        .i_req        (r_in),
        .i_region     (r_region),
        .i_end_offset (r_end_offset),
        .o_res        (calc_res)
    );

    // Input register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_take) begin
            r_in_valid <= 1'b1;
        end else if (advance) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_in <= i_in_data;
        end
    end

    // Result register and end offset.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_end_offset <= 25'd0;
        end else begin
            if (advance) begin
                r_out_valid  <= 1'b1;
                r_end_offset <= calc_res.used_bytes;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_out <= calc_res;
        end
    end

endmodule

[design/fbba_checker.sv]
`timescale 1ns / 1ps
`include "fixed_buffer_bump_allocator_core_macros.svh"

module fbba_checker (
    input logic                i_clk,
    input logic                i_rst_n,
    input logic                o_in_stall,
    input logic                o_out_valid,
    input logic                i_out_stall,
    input fbba_pkg::t_out_beat o_out_data
);
    import fbba_pkg::*;

    // A result beat waits while the consumer stalls.
    `FBBA_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, o_out_valid && i_out_stall, o_out_valid && $stable(o_out_data))

    // A granted request always reports success.
    `FBBA_ASSERT_IMPL(a_grant_ok, i_clk, i_rst_n, o_out_valid && o_out_data.granted, o_out_data.status == ST_OK)

    // A block outside the region is never marked as the last one.
    `FBBA_ASSERT_IMPL(a_notowned_last, i_clk, i_rst_n, o_out_valid && (o_out_data.status == ST_NOTOWNED), !o_out_data.was_last && !o_out_data.granted)

    // Input is only stalled when a result is held back.
    `FBBA_ASSERT(a_stall_cause, i_clk, i_rst_n, !o_in_stall || (o_out_valid && i_out_stall))

endmodule

bind fixed_buffer_bump_allocator_core fbba_checker u_fbba_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .o_in_stall  (o_in_stall),
    .o_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .o_out_data  (o_out_data)
);
